>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the page allocator.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/scpa_pkg.sv
// Shared types and constants of the size class page allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package scpa_pkg;

  // Default configuration of the allocator.
  localparam int PAGE_COUNT_DEF   = 65536;
  localparam int ZONE_BOUND_DEF   = 32768;
  localparam int SIZE_CLASSES_DEF = 16;

  // Width of a class index computed from a bit length (up to 31 bits).
  localparam int CIW = 5;

  typedef struct packed {
    logic        command;
    logic        zone_any;
    logic [15:0] page_start;
    logic [15:0] page_count;
    logic [15:0] min_count;
  } in_t;

  typedef struct packed {
    logic [15:0] granted_start;
    logic [15:0] granted_count;
  } out_t;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_SEARCH,
    OP_U_RD,
    OP_U_LAT,
    OP_U_LN,
    OP_U_LP,
    OP_U_FF,
    OP_U_FL,
    OP_F_SET,
    OP_F_LAST,
    OP_F_FIRST,
    OP_F_HEAD,
    OP_RD_LEFT,
    OP_LEFT_CHK,
    OP_RD_RIGHT,
    OP_RIGHT_CHK,
    OP_F_PREP_REL,
    OP_PART2,
    OP_T_POST,
    OP_T_END,
    OP_OUT
  } dp_op_t;

  // Status flags returned by the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_rel;
    logic rel_ok;
    logic cnt_zero;
    logic found;
    logic zone;
    logic at_zlo;
    logic lmerge;
    logic rin;
    logic rmerge;
    logic tail;
    logic g_zero;
    logic part2;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/size_class_page_allocator.sv
// Top level of the size class page allocator: controller plus datapath.
// Depends on scpa_pkg, scpa_ctrl, scpa_datapath and assert_macros.svh.
//
//   Channel   Ports                          Transaction
//   input     in_valid in_stall in_data      one allocate or release command
//   output    out_valid out_stall out_data   granted start and count
//
// A granting allocate runs search, unlink and, when an unused tail remains, filing before
// the result register; a high zone without a fit, or a zero-length run taken there, is
// followed by a search of the low zone. A zero-count allocate goes straight to output.
// A release checks and merges the neighbors of each zone it covers, then files the run; a bad
// release goes straight to output. The metadata memory has one read and one write port.
// After reset a clearing pass over all PAGE_COUNT records runs before the first item.
// A result waits in the output register while out_stall is high; the next
// command is taken meanwhile and finishes once that register is free.
`include "assert_macros.svh"

module size_class_page_allocator #(
  parameter int PAGE_COUNT   = scpa_pkg::PAGE_COUNT_DEF,
  parameter int ZONE_BOUND   = scpa_pkg::ZONE_BOUND_DEF,
  parameter int SIZE_CLASSES = scpa_pkg::SIZE_CLASSES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  scpa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output scpa_pkg::out_t out_data
);

  scpa_pkg::dp_op_t     op;
  scpa_pkg::dp_status_t st;

  scpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .busy     (in_stall),
    .op       (op)
  );

  scpa_datapath #(
    .PAGE_COUNT   (PAGE_COUNT),
    .ZONE_BOUND   (ZONE_BOUND),
    .SIZE_CLASSES (SIZE_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

  // An accepted transaction keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
               "block not busy after accepting a transaction")
  // The clearing pass never overlaps with taking input.
  `ASSERT_SAME(a_clear_busy, op == scpa_pkg::OP_CLEAR, in_stall,
               "input ready during clearing pass")
  // A result appears only at the end of a command's work.
  `ASSERT_SAME(a_out_after_work, $rose(out_valid), $past(in_stall),
               "result raised without a command in progress")

endmodule

>>> hdl/scpa_datapath.sv
// Datapath of the page allocator: list heads, run metadata memory,
// work registers and the output register. Depends on scpa_pkg.
module scpa_datapath #(
  parameter int PAGE_COUNT   = scpa_pkg::PAGE_COUNT_DEF,
  parameter int ZONE_BOUND   = scpa_pkg::ZONE_BOUND_DEF,
  parameter int SIZE_CLASSES = scpa_pkg::SIZE_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scpa_pkg::dp_op_t     op,
  input  scpa_pkg::in_t        in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output scpa_pkg::out_t       out_data,
  output scpa_pkg::dp_status_t st
);

  localparam int MAXP = (PAGE_COUNT > ZONE_BOUND) ? PAGE_COUNT : ZONE_BOUND;
  localparam int NW   = $clog2(MAXP + 1) + 2;
  localparam int PW   = $clog2(PAGE_COUNT);
  localparam int LW   = $clog2(MAXP + 1);
  localparam int CW   = $clog2(SIZE_CLASSES);
  localparam int NH   = 2 * SIZE_CLASSES;
  localparam int HW   = $clog2(NH);
  localparam int CIW  = scpa_pkg::CIW;
  localparam logic [NW-1:0] PC_N = NW'(PAGE_COUNT);
  localparam logic [NW-1:0] ZB_N = NW'(ZONE_BOUND);

  typedef struct packed {
    logic [LW-1:0] len;
    logic [PW-1:0] nxt;
    logic [PW-1:0] prv;
    logic [CW-1:0] cls;
    logic          flag;
  } rec_t;

  // Reduce a page number below twice the page count into the store.
  function automatic logic [PW-1:0] pg(input logic [NW-1:0] x);
    return (x >= PC_N) ? PW'(x - PC_N) : PW'(x);
  endfunction

  // Number of significant bits of a value.
  function automatic logic [CIW-1:0] bit_len(input logic [NW-1:0] x);
    logic [CIW-1:0] n;
    n = '0;
    for (int i = 0; i < NW; i++) begin
      if (x[i]) n = CIW'(i + 1);
    end
    return n;
  endfunction

  // Index of a list head from zone and class.
  function automatic logic [HW-1:0] hidx(input logic z, input logic [CW-1:0] c);
    return z ? (HW'(SIZE_CLASSES) + HW'(c)) : HW'(c);
  endfunction

  rec_t          mem [PAGE_COUNT];
  rec_t          rdata_r;
  logic [PW-1:0] heads_r [NH];

  logic [PW-1:0] clr_r;
  logic          out_valid_r;
  scpa_pkg::out_t out_data_r;
  logic          part2_r;
  logic          zone_r;
  logic          is_rel_r;
  logic          zany_r;
  logic [NW-1:0] start_r;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] end_r;
  logic [15:0]   minc_r;
  logic [PW-1:0] u_s_r;
  logic [LW-1:0] u_size_r;
  logic [PW-1:0] u_nxt_r;
  logic [PW-1:0] u_prv_r;
  logic [CW-1:0] u_cls_r;
  logic [PW-1:0] t_start_r;
  logic [NW-1:0] f_start_r;
  logic [NW-1:0] f_size_r;
  logic [PW-1:0] f_first_r;
  logic [PW-1:0] f_last_r;
  logic [CW-1:0] f_cls_r;
  logic [PW-1:0] f_head_r;
  logic [15:0]   gs_r;
  logic [15:0]   gc_r;

  logic [NW-1:0] zlo;
  logic [NW-1:0] zhi;
  logic [NW-1:0] sum_sc;
  logic [NW-1:0] rd_len;
  logic          lmerge;
  logic          rmerge;
  logic          split;
  logic [NW-1:0] g;
  logic          out_free;

  logic [CIW-1:0] list_c;
  logic [CIW-1:0] minl_c;
  logic [15:0]    minc_eff;
  logic           up_f;
  logic           dn_f;
  logic [CIW-1:0] up_sel;
  logic [CIW-1:0] dn_sel;
  logic [CIW-1:0] sel;
  logic           found;
  logic [CIW-1:0] f_bl;
  logic [CIW-1:0] f_cls5;
  logic [CW-1:0]  f_cls_c;
  logic [HW-1:0]  hd_raddr;
  logic [PW-1:0]  hd_rdata;

  logic          we_full;
  logic          we_nxt;
  logic          we_prv;
  logic          we_flag;
  logic [PW-1:0] waddr;
  rec_t          wdata;
  logic [PW-1:0] raddr;

  // Zone limits and neighbor checks.
  assign zlo    = zone_r ? ZB_N : '0;
  assign zhi    = zone_r ? PC_N : ZB_N;
  assign sum_sc = start_r + cnt_r;
  assign rd_len = NW'(rdata_r.len);
  assign lmerge = rdata_r.flag && (rd_len != '0) && (rd_len <= start_r - zlo) &&
                  (start_r != rd_len);
  assign rmerge = rdata_r.flag && (rd_len != '0) && (rd_len <= zhi - sum_sc);
  assign split  = (start_r < ZB_N) && (end_r > ZB_N);
  assign g      = (NW'(u_size_r) < cnt_r) ? NW'(u_size_r) : cnt_r;
  assign out_free = !out_valid_r || !out_stall;

  // Class search over the non-empty lists of the current zone.
  always_comb begin
    minc_eff = (minc_r == 16'd0) ? 16'd1 : minc_r;
    list_c   = bit_len(cnt_r - NW'(1));
    minl_c   = bit_len(NW'(minc_eff - 16'd1));
    up_f     = 1'b0;
    dn_f     = 1'b0;
    up_sel   = '0;
    dn_sel   = '0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if ((heads_r[hidx(zone_r, CW'(i))] != '0) && (CIW'(i) >= list_c)) begin
        up_f   = 1'b1;
        up_sel = CIW'(i);
      end
    end
    for (int i = 0; i < SIZE_CLASSES; i++) begin
      if ((heads_r[hidx(zone_r, CW'(i))] != '0) && (CIW'(i) < list_c) &&
          (CIW'(i) >= minl_c)) begin
        dn_f   = 1'b1;
        dn_sel = CIW'(i);
      end
    end
    found = up_f || dn_f;
    sel   = up_f ? up_sel : dn_sel;
  end

  // Class of a run about to be filed, clamped to the top list.
  always_comb begin
    f_bl   = bit_len(f_size_r);
    f_cls5 = f_bl - CIW'(1);
    if (f_cls5 >= CIW'(SIZE_CLASSES)) f_cls5 = CIW'(SIZE_CLASSES - 1);
    f_cls_c = CW'(f_cls5);
  end

  // Read point into the list heads for the selected class or, while filing, the filed class.
  assign hd_raddr = (op == scpa_pkg::OP_F_SET) ? hidx(zone_r, f_cls_c) : hidx(zone_r, CW'(sel));
  assign hd_rdata = heads_r[hd_raddr];

  // Metadata read address.
  always_comb begin
    case (op)
      scpa_pkg::OP_RD_LEFT:  raddr = pg(start_r - NW'(1));
      scpa_pkg::OP_RD_RIGHT: raddr = pg(sum_sc);
      default:               raddr = u_s_r;
    endcase
  end

  // Metadata write port with field enables.
  always_comb begin
    we_full = 1'b0;
    we_nxt  = 1'b0;
    we_prv  = 1'b0;
    we_flag = 1'b0;
    waddr   = u_s_r;
    wdata   = '0;
    case (op)
      scpa_pkg::OP_CLEAR: begin
        we_full = 1'b1;
        waddr   = clr_r;
      end
      scpa_pkg::OP_U_LN: begin
        we_nxt    = (u_prv_r != '0);
        waddr     = u_prv_r;
        wdata.nxt = u_nxt_r;
      end
      scpa_pkg::OP_U_LP: begin
        we_prv    = (u_nxt_r != '0);
        waddr     = u_nxt_r;
        wdata.prv = u_prv_r;
      end
      scpa_pkg::OP_U_FF: begin
        we_flag = 1'b1;
        waddr   = u_s_r;
      end
      scpa_pkg::OP_U_FL: begin
        we_flag = (u_size_r != '0);
        waddr   = pg(NW'(u_s_r) + NW'(u_size_r) - NW'(1));
      end
      scpa_pkg::OP_F_LAST, scpa_pkg::OP_F_FIRST: begin
        we_full    = 1'b1;
        waddr      = (op == scpa_pkg::OP_F_LAST) ? f_last_r : f_first_r;
        wdata.len  = LW'(f_size_r);
        wdata.nxt  = f_head_r;
        wdata.prv  = '0;
        wdata.cls  = f_cls_r;
        wdata.flag = 1'b1;
      end
      scpa_pkg::OP_F_HEAD: begin
        we_prv    = (f_head_r != '0);
        waddr     = f_head_r;
        wdata.prv = f_first_r;
      end
      default: begin
        we_full = 1'b0;
      end
    endcase
  end

  // Run metadata memory with registered read.
  always_ff @(posedge clk) begin
    if (we_full) begin
      mem[waddr] <= wdata;
    end else begin
      if (we_nxt)  mem[waddr].nxt  <= wdata.nxt;
      if (we_prv)  mem[waddr].prv  <= wdata.prv;
      if (we_flag) mem[waddr].flag <= wdata.flag;
    end
    rdata_r <= mem[raddr];
  end

  // Control registers and list heads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      part2_r     <= 1'b0;
      for (int i = 0; i < NH; i++) heads_r[i] <= '0;
    end else begin
      if (op == scpa_pkg::OP_CLEAR) clr_r <= clr_r + PW'(1);
      if ((op == scpa_pkg::OP_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((op == scpa_pkg::OP_U_LN) && (u_prv_r == '0)) heads_r[hidx(zone_r, u_cls_r)] <= u_nxt_r;
      if (op == scpa_pkg::OP_F_HEAD) heads_r[hidx(zone_r, f_cls_r)] <= f_first_r;
      if (op == scpa_pkg::OP_DECODE) part2_r <= is_rel_r && split;
      if (op == scpa_pkg::OP_PART2)  part2_r <= 1'b0;
    end
  end

  // Work registers, stepped by the controller command.
  always_ff @(posedge clk) begin
    case (op)
      scpa_pkg::OP_LOAD: begin
        is_rel_r <= (in_data.command == scpa_pkg::CMD_RELEASE);
        zany_r   <= in_data.zone_any;
        start_r  <= NW'(in_data.page_start);
        cnt_r    <= NW'(in_data.page_count);
        end_r    <= NW'(in_data.page_start) + NW'(in_data.page_count);
        minc_r   <= in_data.min_count;
        gs_r     <= '0;
        gc_r     <= '0;
      end
      scpa_pkg::OP_DECODE: begin
        if (is_rel_r) begin
          zone_r <= (start_r >= ZB_N);
          if (split) cnt_r <= ZB_N - start_r;
        end else begin
          zone_r <= zany_r;
        end
      end
      scpa_pkg::OP_SEARCH: begin
        if (found) begin
          u_s_r     <= hd_rdata;
          t_start_r <= hd_rdata;
        end else if (zone_r) begin
          zone_r <= 1'b0;
        end
      end
      scpa_pkg::OP_U_LAT: begin
        u_size_r <= rdata_r.len;
        u_nxt_r  <= rdata_r.nxt;
        u_prv_r  <= rdata_r.prv;
        u_cls_r  <= rdata_r.cls;
      end
      scpa_pkg::OP_LEFT_CHK: begin
        if (lmerge) begin
          u_s_r   <= pg(start_r - rd_len);
          start_r <= start_r - rd_len;
          cnt_r   <= cnt_r + rd_len;
        end
      end
      scpa_pkg::OP_RIGHT_CHK: begin
        if (rmerge) begin
          u_s_r <= pg(sum_sc);
          cnt_r <= cnt_r + rd_len;
        end
      end
      scpa_pkg::OP_F_PREP_REL: begin
        f_start_r <= start_r;
        f_size_r  <= cnt_r;
      end
      scpa_pkg::OP_F_SET: begin
        f_first_r <= pg(f_start_r);
        f_last_r  <= pg(f_start_r + f_size_r - NW'(1));
        f_cls_r   <= f_cls_c;
        f_head_r  <= hd_rdata;
      end
      scpa_pkg::OP_PART2: begin
        if (part2_r) begin
          zone_r  <= 1'b1;
          start_r <= ZB_N;
          cnt_r   <= end_r - ZB_N;
        end
      end
      scpa_pkg::OP_T_POST: begin
        f_start_r <= NW'(t_start_r) + g;
        f_size_r  <= NW'(u_size_r) - g;
      end
      scpa_pkg::OP_T_END: begin
        gc_r <= 16'(g);
        gs_r <= (g == '0) ? 16'd0 : 16'(t_start_r);
        if ((g == '0) && zone_r) zone_r <= 1'b0;
      end
      scpa_pkg::OP_OUT: begin
        if (out_free) begin
          out_data_r.granted_start <= gs_r;
          out_data_r.granted_count <= gc_r;
        end
      end
      default: begin
        gs_r <= gs_r;
      end
    endcase
  end

  // Status back to the controller.
  always_comb begin
    st.clr_last = (clr_r == PW'(PAGE_COUNT - 1));
    st.is_rel   = is_rel_r;
    st.rel_ok   = (start_r != '0) && (cnt_r != '0) && (end_r <= PC_N);
    st.cnt_zero = (cnt_r == '0);
    st.found    = found;
    st.zone     = zone_r;
    st.at_zlo   = (start_r == zlo);
    st.lmerge   = lmerge;
    st.rin      = (sum_sc < zhi);
    st.rmerge   = rmerge;
    st.tail     = (NW'(u_size_r) > cnt_r);
    st.g_zero   = (g == '0);
    st.part2    = part2_r;
    st.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/scpa_ctrl.sv
// Controller of the page allocator: sequences clearing, search, unlink,
// file and coalesce steps as datapath commands. Depends on scpa_pkg.
module scpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  scpa_pkg::dp_status_t st,
  output logic                 busy,
  output scpa_pkg::dp_op_t     op
);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DECODE, ST_SEARCH,
    ST_U_RD, ST_U_LAT, ST_U_LN, ST_U_LP, ST_U_FF, ST_U_FL,
    ST_F_SET, ST_F_LAST, ST_F_FIRST, ST_F_HEAD,
    ST_RL_RD, ST_RL_CHK, ST_RR_RD, ST_RR_CHK, ST_REL_FILE, ST_REL_END,
    ST_T_POST, ST_T_END, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  // Next state, return point and command.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    op        = scpa_pkg::OP_NOP;
    case (state_r)
      ST_CLR: begin
        op = scpa_pkg::OP_CLEAR;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          op        = scpa_pkg::OP_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        op = scpa_pkg::OP_DECODE;
        if (st.is_rel) state_nxt = st.rel_ok ? ST_RL_RD : ST_OUT;
        else           state_nxt = st.cnt_zero ? ST_OUT : ST_SEARCH;
      end
      ST_SEARCH: begin
        op = scpa_pkg::OP_SEARCH;
        if (st.found) begin
          state_nxt = ST_U_RD;
          ret_nxt   = ST_T_POST;
        end else begin
          state_nxt = st.zone ? ST_SEARCH : ST_OUT;
        end
      end
      ST_U_RD: begin
        op        = scpa_pkg::OP_U_RD;
        state_nxt = ST_U_LAT;
      end
      ST_U_LAT: begin
        op        = scpa_pkg::OP_U_LAT;
        state_nxt = ST_U_LN;
      end
      ST_U_LN: begin
        op        = scpa_pkg::OP_U_LN;
        state_nxt = ST_U_LP;
      end
      ST_U_LP: begin
        op        = scpa_pkg::OP_U_LP;
        state_nxt = ST_U_FF;
      end
      ST_U_FF: begin
        op        = scpa_pkg::OP_U_FF;
        state_nxt = ST_U_FL;
      end
      ST_U_FL: begin
        op        = scpa_pkg::OP_U_FL;
        state_nxt = ret_r;
      end
      ST_F_SET: begin
        op        = scpa_pkg::OP_F_SET;
        state_nxt = ST_F_LAST;
      end
      ST_F_LAST: begin
        op        = scpa_pkg::OP_F_LAST;
        state_nxt = ST_F_FIRST;
      end
      ST_F_FIRST: begin
        op        = scpa_pkg::OP_F_FIRST;
        state_nxt = ST_F_HEAD;
      end
      ST_F_HEAD: begin
        op        = scpa_pkg::OP_F_HEAD;
        state_nxt = ret_r;
      end
      ST_RL_RD: begin
        op        = scpa_pkg::OP_RD_LEFT;
        state_nxt = st.at_zlo ? ST_RR_RD : ST_RL_CHK;
      end
      ST_RL_CHK: begin
        op = scpa_pkg::OP_LEFT_CHK;
        if (st.lmerge) begin
          state_nxt = ST_U_RD;
          ret_nxt   = ST_RR_RD;
        end else begin
          state_nxt = ST_RR_RD;
        end
      end
      ST_RR_RD: begin
        op        = scpa_pkg::OP_RD_RIGHT;
        state_nxt = st.rin ? ST_RR_CHK : ST_REL_FILE;
      end
      ST_RR_CHK: begin
        op = scpa_pkg::OP_RIGHT_CHK;
        if (st.rmerge) begin
          state_nxt = ST_U_RD;
          ret_nxt   = ST_REL_FILE;
        end else begin
          state_nxt = ST_REL_FILE;
        end
      end
      ST_REL_FILE: begin
        op        = scpa_pkg::OP_F_PREP_REL;
        state_nxt = ST_F_SET;
        ret_nxt   = ST_REL_END;
      end
      ST_REL_END: begin
        op        = scpa_pkg::OP_PART2;
        state_nxt = st.part2 ? ST_RL_RD : ST_OUT;
      end
      ST_T_POST: begin
        op = scpa_pkg::OP_T_POST;
        if (st.tail) begin
          state_nxt = ST_F_SET;
          ret_nxt   = ST_T_END;
        end else begin
          state_nxt = ST_T_END;
        end
      end
      ST_T_END: begin
        op        = scpa_pkg::OP_T_END;
        state_nxt = (st.g_zero && st.zone) ? ST_SEARCH : ST_OUT;
      end
      ST_OUT: begin
        op = scpa_pkg::OP_OUT;
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and return point registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the size class page allocator.
// Depends on scpa_pkg and size_class_page_allocator; predicts every grant locally.
module testbench;

  localparam int unsigned PAGES  = 65536;
  localparam int unsigned BOUND  = 32768;
  localparam int unsigned CLASSES = 16;
  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    int unsigned start;
    int unsigned count;
  } page_run_t;

  // Tracks the free-list state of the allocator and checks each grant.
  class grant_tracker;
    int unsigned heads[2*CLASSES];
    int unsigned length[PAGES];
    int unsigned next_pg[PAGES];
    int unsigned prev_pg[PAGES];
    int unsigned cls_of[PAGES];
    bit          edge_flag[PAGES];
    scpa_pkg::out_t pending_grants[$];
    page_run_t   owned[$];
    int          errors;
    int          grants;
    int          releases;

    function int unsigned pg(int unsigned x);
      return x % PAGES;
    endfunction

    function int unsigned blen(int unsigned x);
      int unsigned n;
      n = 0;
      while (x != 0) begin
        n++;
        x >>= 1;
      end
      return n;
    endfunction

    function void file_run(int unsigned zone, int unsigned start, int unsigned size);
      int unsigned c, first, last, head;
      c = blen(size) - 1;
      if (c >= CLASSES) c = CLASSES - 1;
      first = pg(start);
      last = pg(start + size - 1);
      head = heads[zone*CLASSES + c];
      length[last] = size; cls_of[last] = c;
      next_pg[last] = head; prev_pg[last] = 0; edge_flag[last] = 1;
      length[first] = size; cls_of[first] = c;
      next_pg[first] = head; prev_pg[first] = 0; edge_flag[first] = 1;
      if (head != 0) prev_pg[pg(head)] = first;
      heads[zone*CLASSES + c] = first;
    endfunction

    function int unsigned unfile_run(int unsigned zone, int unsigned start);
      int unsigned s, size, nx, pv, c;
      s = pg(start);
      size = length[s];
      nx = next_pg[s];
      pv = prev_pg[s];
      c = cls_of[s] % CLASSES;
      if (pv != 0) next_pg[pg(pv)] = nx;
      else heads[zone*CLASSES + c] = nx;
      if (nx != 0) prev_pg[pg(nx)] = pv;
      edge_flag[s] = 0;
      if (size != 0) edge_flag[pg(s + size - 1)] = 0;
      return size;
    endfunction

    function void release_zone(int unsigned zone, int unsigned start, int unsigned cnt);
      int unsigned lo, hi, len, right, dummy;
      lo = zone ? BOUND : 0;
      hi = zone ? PAGES : BOUND;
      // Merge with a free run ending just below, staying inside the zone.
      if (start != lo && edge_flag[pg(start - 1)]) begin
        len = length[pg(start - 1)];
        if (len != 0 && len <= start - lo && start - len != 0) begin
          dummy = unfile_run(zone, start - len);
          cnt += len;
          start -= len;
        end
      end
      // Merge with a free run starting just above.
      right = start + cnt;
      if (right < hi && edge_flag[pg(right)]) begin
        len = length[pg(right)];
        if (len != 0 && len <= hi - right) begin
          dummy = unfile_run(zone, right);
          cnt += len;
        end
      end
      file_run(zone, start, cnt);
    endfunction

    function int unsigned take_run(int unsigned zone, int unsigned start, int unsigned cnt,
                                   output int unsigned granted);
      int unsigned sz, g;
      sz = unfile_run(zone, start);
      g = (sz < cnt) ? sz : cnt;
      if (sz > g) file_run(zone, start + g, sz - g);
      granted = g;
      return start;
    endfunction

    function int unsigned alloc_zone(int unsigned zone, int unsigned cnt, int unsigned minc,
                                     output int unsigned granted);
      int lst, min_lst, i;
      int unsigned h;
      lst = blen(cnt - 1);
      min_lst = blen(minc - 1);
      // First fit from the request class upward.
      for (i = lst; i < CLASSES; i++) begin
        h = heads[zone*CLASSES + i];
        if (h != 0) return take_run(zone, h, cnt, granted);
      end
      // Fall back to shorter runs down to the minimum class.
      i = lst - 1;
      if (i > int'(CLASSES) - 1) i = int'(CLASSES) - 1;
      for (; i >= min_lst; i--) begin
        h = heads[zone*CLASSES + i];
        if (h != 0) return take_run(zone, h, cnt, granted);
      end
      granted = 0;
      return 0;
    endfunction

    function void note_command(scpa_pkg::in_t cmd);
      int unsigned s, c, m, e, gs, gc;
      scpa_pkg::out_t r;
      s = 32'(cmd.page_start);
      c = 32'(cmd.page_count);
      m = 32'(cmd.min_count);
      gs = 0;
      gc = 0;
      if (cmd.command == scpa_pkg::CMD_RELEASE) begin
        e = s + c;
        releases++;
        if (s != 0 && c != 0 && e <= PAGES) begin
          if (s < BOUND && e > BOUND) begin
            release_zone(0, s, BOUND - s);
            release_zone(1, BOUND, e - BOUND);
          end else begin
            release_zone((s < BOUND) ? 0 : 1, s, c);
          end
        end
      end else if (c != 0) begin
        if (m == 0) m = 1;
        if (cmd.zone_any) gs = alloc_zone(1, c, m, gc);
        if (gc == 0) gs = alloc_zone(0, c, m, gc);
        if (gc == 0) gs = 0;
        if (gc != 0) begin
          grants++;
          owned = {owned, page_run_t'{start: gs, count: gc}};
        end
      end
      r.granted_start = gs[15:0];
      r.granted_count = gc[15:0];
      pending_grants = {pending_grants, r};
    endfunction

    function void check_grant(scpa_pkg::out_t got);
      scpa_pkg::out_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result start=%0d count=%0d", $time,
                 got.granted_start, got.granted_count);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted_start !== want.granted_start) begin
        $display("%0t: granted_start expected %0d actual %0d", $time,
                 want.granted_start, got.granted_start);
        errors++;
      end
      if (got.granted_count !== want.granted_count) begin
        $display("%0t: granted_count expected %0d actual %0d", $time,
                 want.granted_count, got.granted_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  scpa_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  scpa_pkg::out_t out_data;

  grant_tracker tracker;
  bit quiet;
  int stall_left;
  int idle_cycles;
  int sent;

  size_class_page_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitors of both channels; values read here are those sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_command(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_grant(out_data);
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("size_class_page_allocator: mismatch");
      $finish;
    end
  end

  // Presents one command and holds it until the transaction completes.
  task automatic send_cmd(scpa_pkg::in_t cmd);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_release(int unsigned s, int unsigned c);
    scpa_pkg::in_t cmd;
    cmd = '0;
    cmd.command = scpa_pkg::CMD_RELEASE;
    cmd.zone_any = 1'($urandom_range(0, 1));
    cmd.page_start = s[15:0];
    cmd.page_count = c[15:0];
    cmd.min_count = 16'($urandom);
    send_cmd(cmd);
  endtask

  task automatic send_alloc(bit any, int unsigned c, int unsigned m);
    scpa_pkg::in_t cmd;
    cmd = '0;
    cmd.command = scpa_pkg::CMD_ALLOC;
    cmd.zone_any = any;
    cmd.page_start = 16'($urandom);
    cmd.page_count = c[15:0];
    cmd.min_count = m[15:0];
    send_cmd(cmd);
  endtask

  // One random command: mostly well-formed allocate and free traffic.
  task automatic send_random();
    int unsigned pick, c, m, idx;
    page_run_t run;
    scpa_pkg::in_t cmd;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 9))
        0: c = $urandom_range(1, 65535);
        1, 2: c = $urandom_range(1, 4096);
        default: c = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 7))
        0: m = 0;
        1: m = $urandom_range(0, 65535);
        default: m = $urandom_range(1, c);
      endcase
      send_alloc(1'($urandom_range(0, 1)), c, m);
    end else if (pick < 88 && tracker.owned.size() > 0) begin
      idx = $urandom_range(0, tracker.owned.size() - 1);
      run = tracker.owned[idx];
      tracker.owned.delete(idx);
      // Occasionally free only the front part and keep the rest.
      if (run.count > 1 && $urandom_range(0, 4) == 0) begin
        c = $urandom_range(1, run.count - 1);
        tracker.owned = {tracker.owned,
                         page_run_t'{start: run.start + c, count: run.count - c}};
        run.count = c;
      end
      send_release(run.start, run.count);
    end else if (pick < 95) begin
      send_release($urandom_range(1, 65535), $urandom_range(1, 256));
    end else begin
      raw = {$urandom, $urandom};
      cmd = raw[$bits(scpa_pkg::in_t)-1:0];
      send_cmd(cmd);
    end
  endtask

  initial begin
    tracker = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty store, bad releases, boundary and edge cases.
    send_alloc(1'b1, 1, 1);
    send_release(0, 5);
    send_release(7, 0);
    send_release(65530, 10);
    send_release(1, 100);
    send_release(32760, 20);
    send_release(65500, 36);
    send_release(200, 65335);
    send_alloc(1'b0, 0, 1);
    send_alloc(1'b0, 3, 0);
    send_alloc(1'b0, 8, 9);
    send_alloc(1'b1, 65535, 1);
    send_alloc(1'b0, 65535, 65535);
    send_alloc(1'b1, 40000, 16);
    send_alloc(1'b0, 100, 100);
    send_release(50, 10);
    send_release(40, 10);
    send_release(60, 5);
    send_release(40, 25);
    send_alloc(1'b1, 16, 1);
    send_release(101, 99);

    // Random part, with one full drain midway and no idling near the end.
    for (int i = 0; i < 1850; i++) begin
      if (i == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_grants.size() != 0) @(posedge clk);
      end
      if (i == 1650) quiet = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d commands: %0d releases and %0d successful grants checked.",
             sent, tracker.releases, tracker.grants);
    if (tracker.errors == 0) begin
      $display("size_class_page_allocator: match");
    end else begin
      $display("size_class_page_allocator: mismatch");
    end
    $finish;
  end
endmodule

>>> size_class_page_allocator.f
+incdir+hdl
hdl/scpa_pkg.sv
hdl/scpa_datapath.sv
hdl/scpa_ctrl.sv
hdl/size_class_page_allocator.sv
tb/testbench.sv
